### rtl/core/nirle_pkg.sv
package nirle_pkg;

  localparam int unsigned CODE_W    = 16;
  localparam int unsigned UNIT_W    = 12;
  localparam int unsigned BLK_W     = 7;
  localparam int unsigned TIME_W    = 19;
  localparam int unsigned IDX_W     = 7;
  localparam int unsigned SHIFT_W   = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [IDX_W-1:0]  SEGMENTS       = 7'd68;
  localparam logic [IDX_W-1:0]  SEG_HDR_MARK   = 7'd0;
  localparam logic [IDX_W-1:0]  SEG_HDR_SPACE  = 7'd1;
  localparam logic [IDX_W-1:0]  SEG_STOP_MARK  = 7'd66;
  localparam logic [IDX_W-1:0]  SEG_STOP_SPACE = 7'd67;
  localparam logic [IDX_W-1:0]  UNITS_HDR_MARK  = 7'd16;
  localparam logic [IDX_W-1:0]  UNITS_HDR_SPACE = 7'd8;
  localparam logic [IDX_W-1:0]  UNITS_STOP_SPC  = 7'd72;
  localparam logic [IDX_W-1:0]  UNITS_ONE_SPACE = 7'd3;
  localparam logic [IDX_W-1:0]  UNITS_BASE      = 7'd1;
  localparam logic [CNT_W-1:0]  DIV_LAST_STEP  = 5'(TIME_W - 1);

  localparam logic [UNIT_W-1:0] PULSE_RESET = 12'd560;
  localparam logic [UNIT_W-1:0] TICK_RESET  = 12'd16;
  localparam logic [BLK_W-1:0]  BLOCK_RESET = 7'd127;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PULL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_UNIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_UNIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCK  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADV,
    S_MUL,
    S_DIV,
    S_SEG,
    S_EMIT
  } nirle_state_t;

  typedef struct packed {
    logic start_frame;
    logic take_block;
    logic busy_clr;
    logic seg_mul;
    logic div_step;
    logic seg_done;
    logic out_load;
    logic out_real;
  } nirle_cmd_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
    logic idx_more;
    logic div_last;
    logic out_free;
  } nirle_stat_t;

endpackage

### rtl/core/nirle_if.sv
interface nirle_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] code;

  modport source (output valid, kind, code, input ready);
  modport sink (input valid, kind, code, output ready);
endinterface

interface nirle_out_if;
  logic       valid;
  logic       ready;
  logic       valid_res;
  logic [7:0] block_byte;
  logic       last;

  modport source (output valid, valid_res, block_byte, last, input ready);
  modport sink (input valid, valid_res, block_byte, last, output ready);
endinterface

interface nirle_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/nirle_ctrl.sv
module nirle_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_kind,
  output logic                  in_ready,
  input  nirle_pkg::nirle_stat_t stat,
  output nirle_pkg::nirle_cmd_t  cmd
);
  import nirle_pkg::*;

  nirle_state_t state_r, state_nxt;
  logic         pull_r, pull_nxt;
  logic         real_r, real_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pull_r  <= 1'b0;
      real_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pull_r  <= pull_nxt;
      real_r  <= real_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pull_nxt  = pull_r;
    real_nxt  = real_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_START) begin
            cmd.start_frame = 1'b1;
            pull_nxt        = 1'b0;
            state_nxt       = S_ADV;
          end else if (stat.busy) begin
            cmd.take_block = 1'b1;
            pull_nxt       = 1'b1;
            real_nxt       = 1'b1;
            state_nxt      = S_ADV;
          end else begin
            real_nxt  = 1'b0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_ADV: begin
        if (stat.rem_zero && stat.idx_more) begin
          state_nxt = S_MUL;
        end else begin
          cmd.busy_clr = stat.rem_zero;
          state_nxt    = pull_r ? S_EMIT : S_IDLE;
        end
      end
      S_MUL: begin
        cmd.seg_mul = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        cmd.seg_done = 1'b1;
        state_nxt    = S_ADV;
      end
      S_EMIT: begin
        cmd.out_real = real_r;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/nirle_dp.sv
module nirle_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [15:0]            in_code,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [11:0]            cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_valid_res,
  output logic [7:0]             out_block_byte,
  output logic                   out_last,
  input  nirle_pkg::nirle_cmd_t  cmd,
  output nirle_pkg::nirle_stat_t stat
);
  import nirle_pkg::*;

  logic [UNIT_W-1:0]  pulse_r, tick_r;
  logic [BLK_W-1:0]   maxblk_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [IDX_W-1:0]   idx_r;
  logic [TIME_W-1:0]  rem_r;
  logic [UNIT_W-1:0]  resid_r;
  logic               busy_r;
  logic [TIME_W-1:0]  quo_r;
  logic [UNIT_W-1:0]  part_r;
  logic [UNIT_W-1:0]  div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [7:0]         byte_r;
  logic               oval_r, ores_r, olast_r;
  logic [7:0]         obyte_r;

  logic [IDX_W-1:0]   units;
  logic               data_space;
  logic [TIME_W-1:0]  seg_time;
  logic [UNIT_W:0]    trial;
  logic               fits;
  logic [BLK_W-1:0]   blk;
  logic [BLK_W-1:0]   take_n;
  logic [7:0]         hi, lo;

  assign hi = in_code[15:8];
  assign lo = in_code[7:0];

  always_comb begin
    data_space = 1'b0;
    if (idx_r == SEG_HDR_MARK) begin
      units = UNITS_HDR_MARK;
    end else if (idx_r == SEG_HDR_SPACE) begin
      units = UNITS_HDR_SPACE;
    end else if (idx_r == SEG_STOP_MARK) begin
      units = UNITS_BASE;
    end else if (idx_r == SEG_STOP_SPACE) begin
      units = UNITS_STOP_SPC;
    end else if (!idx_r[0]) begin
      units = UNITS_BASE;
    end else begin
      data_space = 1'b1;
      units      = shift_r[0] ? UNITS_ONE_SPACE : UNITS_BASE;
    end
  end

  assign seg_time = TIME_W'(units * pulse_r) + TIME_W'(resid_r);
  assign trial    = {part_r, quo_r[TIME_W-1]};
  assign fits     = trial >= {1'b0, div_r};
  assign blk      = (maxblk_r == '0) ? BLK_W'(1) : maxblk_r;
  assign take_n   = (rem_r < TIME_W'(blk)) ? rem_r[BLK_W-1:0] : blk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r  <= PULSE_RESET;
      tick_r   <= TICK_RESET;
      maxblk_r <= BLOCK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PULSE_UNIT: pulse_r  <= cfg_data;
        REG_TICK_UNIT:  tick_r   <= cfg_data;
        REG_MAX_BLOCK:  maxblk_r <= cfg_data[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      idx_r   <= '0;
      rem_r   <= '0;
      resid_r <= '0;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cmd.start_frame) begin
        shift_r <= {~lo, lo, ~hi, hi};
        idx_r   <= '0;
        rem_r   <= '0;
        resid_r <= '0;
        busy_r  <= 1'b1;
      end
      if (cmd.take_block) begin
        rem_r <= rem_r - TIME_W'(take_n);
      end
      if (cmd.busy_clr) begin
        busy_r <= 1'b0;
      end
      if (cmd.seg_mul) begin
        if (data_space) begin
          shift_r <= {1'b0, shift_r[SHIFT_W-1:1]};
        end
        cnt_r <= '0;
      end
      if (cmd.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.seg_done) begin
        rem_r   <= quo_r;
        resid_r <= part_r;
        idx_r   <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_mul) begin
      quo_r  <= seg_time;
      part_r <= '0;
      div_r  <= (tick_r == '0) ? UNIT_W'(1) : tick_r;
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[TIME_W-2:0], fits};
      part_r <= fits ? UNIT_W'(trial - {1'b0, div_r}) : trial[UNIT_W-1:0];
    end
    if (cmd.take_block) begin
      byte_r <= {idx_r[0], take_n};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.out_load) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ores_r  <= cmd.out_real;
      obyte_r <= cmd.out_real ? byte_r : 8'd0;
      olast_r <= cmd.out_real & ~busy_r;
    end
  end

  assign out_valid      = oval_r;
  assign out_valid_res  = ores_r;
  assign out_block_byte = obyte_r;
  assign out_last       = olast_r;

  assign stat.busy     = busy_r;
  assign stat.rem_zero = (rem_r == '0);
  assign stat.idx_more = (idx_r < SEGMENTS);
  assign stat.div_last = (cnt_r == DIV_LAST_STEP);
  assign stat.out_free = ~oval_r | out_ready;

endmodule

### rtl/core/nec_ir_run_length_encoder_unit.sv
// NEC infrared frame encoder that hands out run-length transmitter bytes one pull item at a
// time. A start item loads each frame segment in turn until one holds ticks, so that the
// first tick is ready. A pull item takes a block of ticks from the current segment and, when
// that empties it, loads the next segments in turn until one holds ticks (many loads when
// pulse_unit is so small that segments hold no ticks). Each segment load runs the restoring
// divider, which yields one quotient bit per cycle for the 19-bit segment time. A new item is
// taken while the previous result still waits in the output register. Configuration writes
// are always accepted and are meant to be made while the block is idle.
module nec_ir_run_length_encoder_unit (
  input logic         clk,
  input logic         rst_n,
  nirle_in_if.sink    in_ch,
  nirle_out_if.source out_ch,
  nirle_cfg_if.sink   cfg_ch
);
  import nirle_pkg::*;

  nirle_cmd_t  cmd;
  nirle_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  nirle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nirle_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_code        (in_ch.code),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_valid_res  (out_ch.valid_res),
    .out_block_byte (out_ch.block_byte),
    .out_last       (out_ch.last),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule
